// File: sv/gbn_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package gbn_pkg;

	localparam int WINDOW_MAX_DEF = 16;
	localparam int BUF_DEPTH_DEF  = 64;
	localparam int MAX_SEGMENT    = 1464;
	localparam int RESULT_CAP     = 16;

	localparam int FUNC_W  = 2;
	localparam int LEN_W   = 11;
	localparam int SEQ_W   = 32;
	localparam int KIND_W  = 2;
	localparam int WIN_W   = 5;
	localparam int TMO_W   = 32;
	localparam int CFG_W   = 32;
	localparam int CFG_IDX_W = 1;

	localparam logic [CFG_IDX_W-1:0] REG_WINDOW  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT = 1'd1;

	localparam logic [WIN_W-1:0] WINDOW_RESET  = 5'd10;
	localparam logic [TMO_W-1:0] TIMEOUT_RESET = 32'd1000;

	typedef enum logic [FUNC_W-1:0] {
		FUNC_ADD  = 2'd0,
		FUNC_ACK  = 2'd1,
		FUNC_TICK = 2'd2
	} func_t;

	localparam logic [KIND_W-1:0] KIND_FIRST  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_RETX   = 2'd1;
	localparam logic [KIND_W-1:0] KIND_REJECT = 2'd2;

	typedef struct packed {
		logic              valid;
		logic              from_ram;
		logic [KIND_W-1:0] kind;
		logic              last;
		logic [SEQ_W-1:0]  seq;
		logic [LEN_W-1:0]  len;
	} emit_req_t;

endpackage
`default_nettype wire

// File: sv/gbn_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module gbn_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64,
	localparam int AW = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

// File: sv/gbn_emit.sv
`timescale 1ns / 1ps
`default_nettype none
module gbn_emit import gbn_pkg::*; #(
	parameter int BUF_DEPTH = BUF_DEPTH_DEF,
	localparam int AW = $clog2(BUF_DEPTH)
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire emit_req_t              req,
	input  wire logic [AW-1:0]          req_slot,
	input  wire logic [SEQ_W+LEN_W-1:0] seg_rdata,
	output logic                        fire,
	output logic                        out_valid,
	input  wire logic                   out_stall,
	output logic      [KIND_W-1:0]      kind,
	output logic      [SEQ_W-1:0]       seq_number,
	output logic      [LEN_W-1:0]       out_length,
	output logic      [AW-1:0]          slot,
	output logic                        last
);

	logic out_valid_q;

	assign fire      = req.valid && (!out_valid_q || !out_stall);
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			kind <= req.kind;
			slot <= req_slot;
			last <= req.last;
			if (req.from_ram) begin
				seq_number <= seg_rdata[SEQ_W+LEN_W-1:LEN_W];
				out_length <= seg_rdata[LEN_W-1:0];
			end else begin
				seq_number <= req.seq;
				out_length <= req.len;
			end
		end
	end

endmodule
`default_nettype wire

// File: sv/gbn_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module gbn_ctrl import gbn_pkg::*; #(
	parameter int WINDOW_MAX = WINDOW_MAX_DEF,
	parameter int BUF_DEPTH  = BUF_DEPTH_DEF,
	localparam int AW = $clog2(BUF_DEPTH)
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   in_valid,
	output logic                        in_stall,
	input  wire logic [FUNC_W-1:0]      func,
	input  wire logic [LEN_W-1:0]       seg_length,
	input  wire logic [SEQ_W-1:0]       ack_number,
	input  wire logic                   cfg_we,
	input  wire logic [CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [CFG_W-1:0]       cfg_wdata,
	output logic                        seg_we,
	output logic      [AW-1:0]          seg_waddr,
	output logic      [SEQ_W+LEN_W-1:0] seg_wdata,
	output logic                        seg_re,
	output logic      [AW-1:0]          seg_raddr,
	input  wire logic [SEQ_W+LEN_W-1:0] seg_rdata,
	output logic                        tim_we,
	output logic      [AW-1:0]          tim_waddr,
	output logic      [SEQ_W-1:0]       tim_wdata,
	output logic                        tim_re,
	output logic      [AW-1:0]          tim_raddr,
	input  wire logic [SEQ_W-1:0]       tim_rdata,
	output emit_req_t                   req,
	output logic      [AW-1:0]          req_slot,
	input  wire logic                   fire
);

	localparam int OW  = $clog2(BUF_DEPTH + 1);
	localparam int UW  = $clog2(WINDOW_MAX + 1);
	localparam int NW  = $clog2(RESULT_CAP + 1);
	localparam int CW0 = (OW > UW) ? OW : UW;
	localparam int CW  = (CW0 > WIN_W) ? CW0 : WIN_W;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ACK,
		ST_SEND,
		ST_TCHK,
		ST_RESEND,
		ST_REJ
	} state_t;

	state_t            state_q;
	logic [AW-1:0]     head_q, tail_q, unsent_q, walk_q;
	logic [OW-1:0]     occ_q;
	logic [UW-1:0]     unack_q;
	logic [SEQ_W-1:0]  nseq_q, now_q, ack_q;
	logic [WIN_W-1:0]  window_q;
	logic [TMO_W-1:0]  timeout_q;
	logic [LEN_W-1:0]  rej_len_q;
	logic [NW-1:0]     n_q;
	logic              ack_pend_q;
	logic              pend_s1;
	logic [KIND_W-1:0] kind_s1;
	logic [AW-1:0]     slot_s1;

	logic [LEN_W-1:0]  len_sat;
	logic [CW-1:0]     win_c, unack_x, occ_x, n_x;
	logic              full, in_accept, issue_ok;
	logic              cond_send, cond_resend, send_issue, resend_issue, ack_issue;
	logic [SEQ_W-1:0]  ack_d, age;
	logic              below, timed_out;

	function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
		return (p == AW'(BUF_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_comb begin
		win_c = CW'(window_q);
		if (win_c == '0) begin
			win_c = CW'(1);
		end else if (win_c > CW'(WINDOW_MAX)) begin
			win_c = CW'(WINDOW_MAX);
		end
	end

	assign len_sat   = (seg_length > LEN_W'(MAX_SEGMENT)) ? LEN_W'(MAX_SEGMENT) : seg_length;
	assign unack_x   = CW'(unack_q);
	assign occ_x     = CW'(occ_q);
	assign n_x       = CW'(n_q);
	assign full      = occ_q >= OW'(BUF_DEPTH);
	assign in_accept = in_valid && (state_q == ST_IDLE);
	assign in_stall  = state_q != ST_IDLE;
	assign issue_ok  = !pend_s1 || fire;

	assign cond_send   = (unack_x < win_c) && (unack_x < occ_x) && (n_q < NW'(RESULT_CAP));
	assign cond_resend = (n_x < unack_x) && (n_q < NW'(RESULT_CAP));
	assign send_issue   = (state_q == ST_SEND) && cond_send && issue_ok;
	assign resend_issue = (state_q == ST_RESEND) && cond_resend && issue_ok;

	assign ack_d     = ack_q - seg_rdata[SEQ_W+LEN_W-1:LEN_W];
	assign below     = (ack_d != '0) && !ack_d[SEQ_W-1];
	assign ack_issue = (state_q == ST_ACK) &&
		(ack_pend_q ? (below && (unack_q > UW'(1))) : (unack_q != '0));
	assign age       = now_q - tim_rdata;
	assign timed_out = age > timeout_q;

	assign seg_we    = in_accept && (func == FUNC_ADD) && !full;
	assign seg_waddr = tail_q;
	assign seg_wdata = {nseq_q, len_sat};
	assign seg_re    = send_issue || resend_issue || ack_issue;

	always_comb begin
		priority if (state_q == ST_ACK) begin
			seg_raddr = ack_pend_q ? ptr_inc(head_q) : head_q;
		end else if (state_q == ST_SEND) begin
			seg_raddr = unsent_q;
		end else begin
			seg_raddr = walk_q;
		end
	end

	assign tim_re    = in_accept && (func == FUNC_TICK) && (unack_q != '0);
	assign tim_raddr = head_q;
	assign tim_we    = fire && req.from_ram;
	assign tim_waddr = slot_s1;
	assign tim_wdata = now_q;

	always_comb begin
		req.valid    = pend_s1 || (state_q == ST_REJ);
		req.from_ram = pend_s1;
		req.kind     = (state_q == ST_REJ) ? KIND_REJECT : kind_s1;
		req.seq      = nseq_q;
		req.len      = rej_len_q;
		priority if (state_q == ST_REJ) begin
			req.last = 1'b1;
		end else if (state_q == ST_SEND) begin
			req.last = !cond_send;
		end else begin
			req.last = !cond_resend;
		end
		req_slot = (state_q == ST_REJ) ? '0 : slot_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			head_q     <= '0;
			tail_q     <= '0;
			unsent_q   <= '0;
			walk_q     <= '0;
			occ_q      <= '0;
			unack_q    <= '0;
			nseq_q     <= '0;
			now_q      <= '0;
			ack_q      <= '0;
			window_q   <= WINDOW_RESET;
			timeout_q  <= TIMEOUT_RESET;
			rej_len_q  <= '0;
			n_q        <= '0;
			ack_pend_q <= 1'b0;
			pend_s1    <= 1'b0;
			kind_s1    <= KIND_FIRST;
			slot_s1    <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_WINDOW:  window_q  <= cfg_wdata[WIN_W-1:0];
					REG_TIMEOUT: timeout_q <= cfg_wdata[TMO_W-1:0];
				endcase
			end
			pend_s1 <= send_issue || resend_issue || (pend_s1 && !fire);
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						n_q <= '0;
						unique case (func)
							FUNC_ADD: begin
								if (full) begin
									rej_len_q <= len_sat;
									state_q   <= ST_REJ;
								end else begin
									tail_q  <= ptr_inc(tail_q);
									occ_q   <= occ_q + 1'b1;
									nseq_q  <= nseq_q + SEQ_W'(len_sat);
									state_q <= ST_SEND;
								end
							end
							FUNC_ACK: begin
								ack_q      <= ack_number;
								ack_pend_q <= 1'b0;
								state_q    <= ST_ACK;
							end
							FUNC_TICK: begin
								now_q <= now_q + 1'b1;
								if (unack_q != '0) begin
									state_q <= ST_TCHK;
								end
							end
							default: ;
						endcase
					end
				end
				ST_ACK: begin
					if (ack_pend_q) begin
						if (below) begin
							head_q     <= ptr_inc(head_q);
							occ_q      <= occ_q - 1'b1;
							unack_q    <= unack_q - 1'b1;
							ack_pend_q <= unack_q > UW'(1);
						end else begin
							ack_pend_q <= 1'b0;
							state_q    <= ST_SEND;
						end
					end else if (unack_q != '0) begin
						ack_pend_q <= 1'b1;
					end else begin
						state_q <= ST_SEND;
					end
				end
				ST_SEND: begin
					if (send_issue) begin
						unsent_q <= ptr_inc(unsent_q);
						unack_q  <= unack_q + 1'b1;
						n_q      <= n_q + 1'b1;
						kind_s1  <= KIND_FIRST;
						slot_s1  <= unsent_q;
					end else if (issue_ok) begin
						state_q <= ST_IDLE;
					end
				end
				ST_TCHK: begin
					if (timed_out) begin
						walk_q  <= head_q;
						state_q <= ST_RESEND;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_RESEND: begin
					if (resend_issue) begin
						walk_q  <= ptr_inc(walk_q);
						n_q     <= n_q + 1'b1;
						kind_s1 <= KIND_RETX;
						slot_s1 <= walk_q;
					end else if (issue_ok) begin
						state_q <= ST_IDLE;
					end
				end
				ST_REJ: begin
					if (fire) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

// File: sv/go_back_n_send_window.sv
// channel   signals                                       moves
// request   in_valid in_stall func seg_length ack_number  one add, ack or tick per request
// result    out_valid out_stall kind seq_number           one send, resend or reject each
//           out_length slot last
// config    cfg_we cfg_index cfg_wdata                    one register write per edge
//
// Add: stores the segment, then sends what the window allows; a full buffer gives a reject.
// Ack: frees each acknowledged segment, then sends what the window allows.
// Tick: advances time; if the oldest segment timed out, resends the unacked ones; at most 16 results.
// The single read port of the segment RAM sets the one-result-per-cycle walk.
// Reset clears pointers and counters and loads the config defaults; no RAM clearing pass. Output stall holds the walk.
`timescale 1ns / 1ps
`default_nettype none
module go_back_n_send_window import gbn_pkg::*; #(
	parameter int WINDOW_MAX = WINDOW_MAX_DEF,
	parameter int BUF_DEPTH  = BUF_DEPTH_DEF,
	localparam int AW = $clog2(BUF_DEPTH)
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire logic [FUNC_W-1:0]    func,
	input  wire logic [LEN_W-1:0]     seg_length,
	input  wire logic [SEQ_W-1:0]     ack_number,
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output logic      [KIND_W-1:0]    kind,
	output logic      [SEQ_W-1:0]     seq_number,
	output logic      [LEN_W-1:0]     out_length,
	output logic      [AW-1:0]        slot,
	output logic                      last,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_wdata
);

	logic                   seg_we, seg_re, tim_we, tim_re, fire;
	logic [AW-1:0]          seg_waddr, seg_raddr, tim_waddr, tim_raddr, req_slot;
	logic [SEQ_W+LEN_W-1:0] seg_wdata, seg_rdata;
	logic [SEQ_W-1:0]       tim_wdata, tim_rdata;
	emit_req_t              req;

	gbn_ram #(.WIDTH(SEQ_W + LEN_W), .DEPTH(BUF_DEPTH)) u_seg_ram (
		.clk   (clk),
		.we    (seg_we),
		.waddr (seg_waddr),
		.wdata (seg_wdata),
		.re    (seg_re),
		.raddr (seg_raddr),
		.rdata (seg_rdata)
	);

	gbn_ram #(.WIDTH(SEQ_W), .DEPTH(BUF_DEPTH)) u_tim_ram (
		.clk   (clk),
		.we    (tim_we),
		.waddr (tim_waddr),
		.wdata (tim_wdata),
		.re    (tim_re),
		.raddr (tim_raddr),
		.rdata (tim_rdata)
	);

	gbn_ctrl #(.WINDOW_MAX(WINDOW_MAX), .BUF_DEPTH(BUF_DEPTH)) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.func       (func),
		.seg_length (seg_length),
		.ack_number (ack_number),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.seg_we     (seg_we),
		.seg_waddr  (seg_waddr),
		.seg_wdata  (seg_wdata),
		.seg_re     (seg_re),
		.seg_raddr  (seg_raddr),
		.seg_rdata  (seg_rdata),
		.tim_we     (tim_we),
		.tim_waddr  (tim_waddr),
		.tim_wdata  (tim_wdata),
		.tim_re     (tim_re),
		.tim_raddr  (tim_raddr),
		.tim_rdata  (tim_rdata),
		.req        (req),
		.req_slot   (req_slot),
		.fire       (fire)
	);

	gbn_emit #(.BUF_DEPTH(BUF_DEPTH)) u_emit (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.req_slot   (req_slot),
		.seg_rdata  (seg_rdata),
		.fire       (fire),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.kind       (kind),
		.seq_number (seq_number),
		.out_length (out_length),
		.slot       (slot),
		.last       (last)
	);

endmodule
`default_nettype wire
